// ===== rtl/pwpt_pkg.sv =====
// Package: shared constants, command codes and sequencer states for the polygon point test.
package pwpt_pkg;

  // ring capacity and coordinate width
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
  localparam int COUNT_BITS   = ADDR_BITS + 1;

  // arithmetic widths: operands carry one extra bit for edge differences
  localparam int OPND_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * OPND_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  // result field widths
  localparam int WIND_BITS   = 10;
  localparam int BORDER_BITS = 9;
  localparam int AREA_BITS   = 41;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // query sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_GETE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_EVAL,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/pwpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pwpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/polygon_winding_point_test.sv =====
// Top level: polygon ring store with an iterative winding-number and area query engine.
//
//   channel | dir | ports                                          | beat
//   --------+-----+------------------------------------------------+---------------------------
//   in_     | in  | in_cmd, in_coord_x, in_coord_y                 | clear, append or query
//   out_    | out | out_winding_number, out_border_hits,           | one per query
//           |     | out_inside_res, out_twice_area                 |
//
// A query runs each edge through one shared 17x17 signed multiplier for four products,
// plus a vertex fetch from the RAM (not for the closing edge) and an evaluate step;
// an empty ring goes straight to the final step.
// Synchronous active-low reset empties the ring; vertex RAM contents are not cleared.
// in_ready is low while a query walks the ring, and a finished result waits in the
// output register; the sequencer holds in its final state while that register is full.
module polygon_winding_point_test (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_cmd,
  input  logic signed [pwpt_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [pwpt_pkg::COORD_BITS-1:0] in_coord_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pwpt_pkg::WIND_BITS-1:0]  out_winding_number,
  output logic [pwpt_pkg::BORDER_BITS-1:0]       out_border_hits,
  output logic                                   out_inside_res,
  output logic signed [pwpt_pkg::AREA_BITS-1:0]  out_twice_area
);

  localparam int CW = pwpt_pkg::COORD_BITS;
  localparam int AW = pwpt_pkg::ADDR_BITS;
  localparam int NW = pwpt_pkg::COUNT_BITS;
  localparam int OW = pwpt_pkg::OPND_BITS;
  localparam int PW = pwpt_pkg::PROD_BITS;
  localparam int XW = pwpt_pkg::CROSS_BITS;
  localparam int WW = pwpt_pkg::WIND_BITS;
  localparam int BW = pwpt_pkg::BORDER_BITS;
  localparam int RW = pwpt_pkg::AREA_BITS;

  pwpt_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]        count_r;
  logic [AW-1:0]        idx_r;
  logic                 last_r;
  logic signed [CW-1:0] px_r, py_r;
  logic signed [CW-1:0] first_x_r, first_y_r;
  logic signed [CW-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [PW-1:0] prod_r, cr_r;
  logic signed [RW-1:0] area_r;
  logic signed [WW-1:0] wind_r;
  logic [BW-1:0]        border_r;
  logic                 out_valid_r;

  logic                 in_acc;
  logic                 is_query, is_append, is_clear;
  logic                 out_free;
  logic                 at_closing;
  logic                 ram_wr_en, ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic signed [CW-1:0] rd_x, rd_y;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_nxt;
  logic signed [XW-1:0] cross_v;
  logic                 starts_below, ends_below, straddle;
  logic                 c_zero, c_pos;

  assign is_query   = (pwpt_pkg::cmd_t'(in_cmd) == pwpt_pkg::CMD_QUERY);
  assign is_append  = (pwpt_pkg::cmd_t'(in_cmd) == pwpt_pkg::CMD_APPEND);
  assign is_clear   = (pwpt_pkg::cmd_t'(in_cmd) == pwpt_pkg::CMD_CLEAR);
  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign at_closing = ((NW'(idx_r) + NW'(1)) == count_r);

  // vertex stores
  assign ram_wr_en = in_acc && is_append && (count_r < NW'(pwpt_pkg::MAX_VERTICES));

  pwpt_ram #(.WIDTH(CW), .DEPTH(pwpt_pkg::MAX_VERTICES)) u_ram_x (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_coord_x),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_x)
  );

  pwpt_ram #(.WIDTH(CW), .DEPTH(pwpt_pkg::MAX_VERTICES)) u_ram_y (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_coord_y),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_y)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwpt_pkg::ST_IDLE: begin
        if (in_valid && is_query) begin
          state_nxt = (count_r == '0) ? pwpt_pkg::ST_FIN : pwpt_pkg::ST_FIRST;
        end
      end
      pwpt_pkg::ST_FIRST: begin
        state_nxt = (count_r == NW'(1)) ? pwpt_pkg::ST_M0 : pwpt_pkg::ST_GETE;
      end
      pwpt_pkg::ST_GETE: state_nxt = pwpt_pkg::ST_M0;
      pwpt_pkg::ST_M0:   state_nxt = pwpt_pkg::ST_M1;
      pwpt_pkg::ST_M1:   state_nxt = pwpt_pkg::ST_M2;
      pwpt_pkg::ST_M2:   state_nxt = pwpt_pkg::ST_M3;
      pwpt_pkg::ST_M3:   state_nxt = pwpt_pkg::ST_EVAL;
      pwpt_pkg::ST_EVAL: begin
        if (last_r) begin
          state_nxt = pwpt_pkg::ST_FIN;
        end else if (at_closing) begin
          state_nxt = pwpt_pkg::ST_M0;
        end else begin
          state_nxt = pwpt_pkg::ST_GETE;
        end
      end
      pwpt_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = pwpt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pwpt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, RAM read and multiplier operand select
  always_comb begin
    in_ready    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_r)
      pwpt_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ram_rd_en = in_valid && is_query;
      end
      pwpt_pkg::ST_FIRST: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = AW'(1);
      end
      pwpt_pkg::ST_M0: begin
        mul_a = OW'(sx_r);
        mul_b = OW'(ey_r);
      end
      pwpt_pkg::ST_M1: begin
        mul_a = OW'(ex_r);
        mul_b = OW'(sy_r);
      end
      pwpt_pkg::ST_M2: begin
        mul_a = OW'(ex_r) - OW'(sx_r);
        mul_b = OW'(py_r) - OW'(sy_r);
      end
      pwpt_pkg::ST_M3: begin
        mul_a = OW'(ey_r) - OW'(sy_r);
        mul_b = OW'(px_r) - OW'(sx_r);
      end
      pwpt_pkg::ST_EVAL: begin
        ram_rd_en   = !last_r && !at_closing;
        ram_rd_addr = idx_r + AW'(1);
      end
      pwpt_pkg::ST_GETE, pwpt_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // shared multiplier
  assign prod_nxt = mul_a * mul_b;

  // edge evaluation
  assign cross_v      = XW'(cr_r) - XW'(prod_r);
  assign starts_below = (sy_r <= py_r);
  assign ends_below   = (ey_r <= py_r);
  assign straddle     = (starts_below != ends_below);
  assign c_zero       = (cross_v == '0);
  assign c_pos        = !cross_v[XW-1] && !c_zero;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwpt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && is_clear) begin
        count_r <= '0;
      end else if (ram_wr_en) begin
        count_r <= count_r + NW'(1);
      end
      // a new result refills the register even while the old one leaves
      if (state_r == pwpt_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      pwpt_pkg::ST_IDLE: begin
        if (in_valid && is_query) begin
          px_r     <= in_coord_x;
          py_r     <= in_coord_y;
          area_r   <= '0;
          wind_r   <= '0;
          border_r <= '0;
          last_r   <= 1'b0;
        end
      end
      pwpt_pkg::ST_FIRST: begin
        first_x_r <= rd_x;
        first_y_r <= rd_y;
        sx_r      <= rd_x;
        sy_r      <= rd_y;
        ex_r      <= rd_x;
        ey_r      <= rd_y;
        idx_r     <= AW'(1);
        last_r    <= (count_r == NW'(1));
      end
      pwpt_pkg::ST_GETE: begin
        ex_r <= rd_x;
        ey_r <= rd_y;
      end
      pwpt_pkg::ST_M0: begin
        prod_r <= prod_nxt;
      end
      pwpt_pkg::ST_M1: begin
        area_r <= area_r + RW'(prod_r);
        prod_r <= prod_nxt;
      end
      pwpt_pkg::ST_M2: begin
        area_r <= area_r - RW'(prod_r);
        prod_r <= prod_nxt;
      end
      pwpt_pkg::ST_M3: begin
        cr_r   <= prod_r;
        prod_r <= prod_nxt;
      end
      pwpt_pkg::ST_EVAL: begin
        if (straddle) begin
          if (!ends_below && c_pos) begin
            wind_r <= wind_r + WW'(1);
          end else if (ends_below && !c_pos) begin
            wind_r <= wind_r - WW'(1);
          end
          if (c_zero) begin
            border_r <= border_r + BW'(1);
          end
        end
        sx_r <= ex_r;
        sy_r <= ey_r;
        if (!last_r) begin
          if (at_closing) begin
            ex_r   <= first_x_r;
            ey_r   <= first_y_r;
            last_r <= 1'b1;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
      end
      pwpt_pkg::ST_FIN: begin
        if (out_free) begin
          out_winding_number <= wind_r;
          out_border_hits    <= border_r;
          out_inside_res     <= (wind_r != '0);
          out_twice_area     <= area_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // ring size is frozen while a query walks it
  a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pwpt_pkg::ST_IDLE) |=> $stable(count_r))
    else $error("vertex count changed during a query");

  // ring never grows past capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(pwpt_pkg::MAX_VERTICES))
    else $error("vertex count above capacity");

  // fetches only touch written vertices
  a_fetch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pwpt_pkg::ST_GETE) |-> (NW'(idx_r) < count_r))
    else $error("vertex fetch beyond ring");

  // a result appears only from the final sequencer step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == pwpt_pkg::ST_FIN))
    else $error("result raised outside final step");

endmodule
